// ===== rtl/signal_pending_delivery_macros.svh =====
// Assertion macros for the signal controller.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef SIGNAL_PENDING_DELIVERY_MACROS_SVH
`define SIGNAL_PENDING_DELIVERY_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("signal_pending_delivery: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SPD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("signal_pending_delivery: next-cycle check failed");

`endif

// ===== rtl/spd_pkg.sv =====
`default_nettype none

package spd_pkg;

  localparam int NUM_SIGNALS = 64;
  localparam int MASK_W      = 64;
  localparam int SIG_W       = 6;

  localparam logic [SIG_W-1:0] FIRST_SIG = SIG_W'(1);
  localparam logic [SIG_W-1:0] LAST_SIG  = SIG_W'(NUM_SIGNALS - 1);
  localparam logic [SIG_W:0]   SIG_LIMIT = (SIG_W + 1)'(NUM_SIGNALS);

  localparam logic [SIG_W-1:0] SIG_KILL = SIG_W'(9);
  localparam logic [SIG_W-1:0] SIG_CHLD = SIG_W'(17);
  localparam logic [SIG_W-1:0] SIG_CONT = SIG_W'(18);
  localparam logic [SIG_W-1:0] SIG_STOP = SIG_W'(19);
  localparam logic [SIG_W-1:0] SIG_TSTP = SIG_W'(20);

  typedef enum logic [1:0] {
    REQ_SEND    = 2'd0,
    REQ_DELIVER = 2'd1,
    REQ_INIT    = 2'd2
  } req_t;

  localparam logic [1:0] TS_UNUSED  = 2'd0;
  localparam logic [1:0] TS_ZOMBIE  = 2'd1;
  localparam logic [1:0] TS_RUNNING = 2'd2;

  typedef enum logic [1:0] {
    CFG_BLOCKED = 2'd0,
    CFG_IGNORE  = 2'd1,
    CFG_CUSTOM  = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_DONE = 2'd2
  } seq_state_t;

  // Verdict of the evaluator for the signal under the scan index.
  typedef struct packed {
    logic hit;   // pending and deliverable, so its pending bit is cleared
    logic term;  // its action terminates the task
  } eval_t;

  typedef struct packed {
    logic             idle;
    logic             scan;
    logic             load_out;
    logic [SIG_W-1:0] idx;
  } seq_ctrl_t;

  // Default action: every signal but child, continue, stop and terminal-stop terminates the task.
  function automatic logic default_terminates(input logic [SIG_W-1:0] s);
    return !(s == SIG_CHLD || s == SIG_CONT || s == SIG_STOP || s == SIG_TSTP);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/spd_eval.sv =====
`default_nettype none

// Evaluates one signal per cycle: selects its bits from the masks and decides its fate.
module spd_eval (
  input  wire logic [spd_pkg::SIG_W-1:0]  idx,
  input  wire logic [spd_pkg::MASK_W-1:0] pending,
  input  wire logic [spd_pkg::MASK_W-1:0] blocked,
  input  wire logic [spd_pkg::MASK_W-1:0] ignored,
  input  wire logic [spd_pkg::MASK_W-1:0] custom,
  output spd_pkg::eval_t                  verdict
);

  logic is_kill;

  assign is_kill = (idx == spd_pkg::SIG_KILL);

  always_comb begin
    verdict.hit  = pending[idx] && (is_kill || !blocked[idx]);
    verdict.term = is_kill ||
                   (!ignored[idx] && !custom[idx] && spd_pkg::default_terminates(idx));
  end

endmodule

`default_nettype wire

// ===== rtl/spd_seq.sv =====
`default_nettype none

// Sequencer: takes a request, steps the scan index and hands the result to the output.
module spd_seq (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic          start_scan,
  input  wire spd_pkg::eval_t verdict,
  input  wire logic          out_free,
  output spd_pkg::seq_ctrl_t ctrl
);

  spd_pkg::seq_state_t          state_r, state_nxt;
  logic [spd_pkg::SIG_W-1:0]    idx_r, idx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spd_pkg::S_IDLE;
      idx_r   <= spd_pkg::FIRST_SIG;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      spd_pkg::S_IDLE: begin
        if (start) begin
          state_nxt = start_scan ? spd_pkg::S_SCAN : spd_pkg::S_DONE;
        end
      end
      spd_pkg::S_SCAN: begin
        if ((verdict.hit && verdict.term) || (idx_r == spd_pkg::LAST_SIG)) begin
          state_nxt = spd_pkg::S_DONE;
        end
      end
      spd_pkg::S_DONE: begin
        if (out_free) begin
          state_nxt = spd_pkg::S_IDLE;
        end
      end
      default: state_nxt = spd_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctrl.idle     = 1'b0;
    ctrl.scan     = 1'b0;
    ctrl.load_out = 1'b0;
    ctrl.idx      = idx_r;
    idx_nxt       = idx_r;
    unique case (state_r)
      spd_pkg::S_IDLE: begin
        ctrl.idle = 1'b1;
        idx_nxt   = spd_pkg::FIRST_SIG;
      end
      spd_pkg::S_SCAN: begin
        ctrl.scan = 1'b1;
        idx_nxt   = idx_r + spd_pkg::SIG_W'(1);
      end
      spd_pkg::S_DONE: begin
        ctrl.load_out = out_free;
      end
      default: begin
        idx_nxt = spd_pkg::FIRST_SIG;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/signal_pending_delivery.sv =====
// A request that needs no scan goes to S_DONE and loads the output register once it is free;
// a deliver to a running task first scans one signal per cycle, from signal 1 upward.
// Throughput: one word at a time; the next input word is taken once the result is registered.
// The scan length is set by the single shared signal evaluator, visited once per signal.
// Reset (rst_n, synchronous, active low) clears the pending mask and all three masks.
`default_nettype none

`include "signal_pending_delivery_macros.svh"

module signal_pending_delivery (
  input  wire logic                          clk,
  input  wire logic                          rst_n,

  // Input word channel.
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    in_req_type,
  input  wire logic [spd_pkg::SIG_W-1:0]     in_signal_number,
  input  wire logic [1:0]                    in_task_status,

  // Result word channel.
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_send_accepted,
  output logic                               out_terminate,
  output logic [spd_pkg::SIG_W-1:0]          out_term_signal,
  output logic [spd_pkg::MASK_W-1:0]         out_pending_after,

  // Configuration write channel.
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [spd_pkg::MASK_W-1:0]    cfg_data
);

  // Architectural state: the pending mask and the three handler masks.
  logic [spd_pkg::MASK_W-1:0] pending_r, pending_nxt;
  logic [spd_pkg::MASK_W-1:0] blocked_r, blocked_nxt;
  logic [spd_pkg::MASK_W-1:0] ignore_r, ignore_nxt;
  logic [spd_pkg::MASK_W-1:0] custom_r, custom_nxt;

  // Per-word working registers, gathered while the word is processed.
  logic                       accepted_r, accepted_nxt;
  logic                       term_r, term_nxt;
  logic [spd_pkg::SIG_W-1:0]  fatal_sig_r, fatal_sig_nxt;

  // Output register, which parts the result side from the input side.
  logic                       out_valid_r, out_valid_nxt;
  logic                       out_acc_r;
  logic                       out_term_r;
  logic [spd_pkg::SIG_W-1:0]  out_sig_r;
  logic [spd_pkg::MASK_W-1:0] out_pend_r;

  spd_pkg::seq_ctrl_t ctrl;
  spd_pkg::eval_t     verdict;

  logic in_fire;
  logic cfg_fire;
  logic out_free;
  logic send_ok;
  logic start_scan;

  assign in_stall  = !ctrl.idle;
  assign in_fire   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  // The output register may be reloaded when it is empty or its word leaves this cycle.
  assign out_free = !out_valid_r || !out_stall;

  // A send is honoured for signals 1 up to the last one, and only for a live task.
  assign send_ok = (in_req_type == spd_pkg::REQ_SEND) &&
                   (in_signal_number != {spd_pkg::SIG_W{1'b0}}) &&
                   ({1'b0, in_signal_number} < spd_pkg::SIG_LIMIT) &&
                   (in_task_status != spd_pkg::TS_UNUSED) &&
                   (in_task_status != spd_pkg::TS_ZOMBIE);

  // Only a deliver to a running task starts the scan; every other request finishes at once.
  assign start_scan = (in_req_type == spd_pkg::REQ_DELIVER) &&
                      (in_task_status == spd_pkg::TS_RUNNING);

  spd_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (in_fire),
    .start_scan (start_scan),
    .verdict    (verdict),
    .out_free   (out_free),
    .ctrl       (ctrl)
  );

  // The evaluator is shared by every step of the scan; the index walks upward from signal 1.
  spd_eval u_eval (
    .idx     (ctrl.idx),
    .pending (pending_r),
    .blocked (blocked_r),
    .ignored (ignore_r),
    .custom  (custom_r),
    .verdict (verdict)
  );

  always_comb begin
    pending_nxt   = pending_r;
    blocked_nxt   = blocked_r;
    ignore_nxt    = ignore_r;
    custom_nxt    = custom_r;
    accepted_nxt  = accepted_r;
    term_nxt      = term_r;
    fatal_sig_nxt = fatal_sig_r;

    // The user must make configuration writes only while the block is idle; the block itself
    // does not enforce this. An index beyond the three masks is accepted and has no effect.
    if (cfg_fire) begin
      unique case (cfg_index)
        spd_pkg::CFG_BLOCKED: blocked_nxt = cfg_data;
        spd_pkg::CFG_IGNORE:  ignore_nxt  = cfg_data;
        spd_pkg::CFG_CUSTOM:  custom_nxt  = cfg_data;
        default: ;
      endcase
    end

    if (in_fire) begin
      accepted_nxt  = send_ok;
      term_nxt      = 1'b0;
      fatal_sig_nxt = {spd_pkg::SIG_W{1'b0}};
      if (send_ok) begin
        pending_nxt = pending_r | (spd_pkg::MASK_W'(1) << in_signal_number);
      end
      if (in_req_type == spd_pkg::REQ_INIT) begin
        // Init returns every handler to its default and unblocks everything.
        pending_nxt = {spd_pkg::MASK_W{1'b0}};
        blocked_nxt = {spd_pkg::MASK_W{1'b0}};
        ignore_nxt  = {spd_pkg::MASK_W{1'b0}};
        custom_nxt  = {spd_pkg::MASK_W{1'b0}};
      end
    end

    // A deliverable signal is cleared whatever its action; a terminating one ends the scan.
    if (ctrl.scan && verdict.hit) begin
      pending_nxt = pending_r & ~(spd_pkg::MASK_W'(1) << ctrl.idx);
      if (verdict.term) begin
        term_nxt      = 1'b1;
        fatal_sig_nxt = ctrl.idx;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctrl.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r   <= {spd_pkg::MASK_W{1'b0}};
      blocked_r   <= {spd_pkg::MASK_W{1'b0}};
      ignore_r    <= {spd_pkg::MASK_W{1'b0}};
      custom_r    <= {spd_pkg::MASK_W{1'b0}};
      out_valid_r <= 1'b0;
    end else begin
      pending_r   <= pending_nxt;
      blocked_r   <= blocked_nxt;
      ignore_r    <= ignore_nxt;
      custom_r    <= custom_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and output payload registers need no reset.
  always_ff @(posedge clk) begin
    accepted_r  <= accepted_nxt;
    term_r      <= term_nxt;
    fatal_sig_r <= fatal_sig_nxt;
    if (ctrl.load_out) begin
      out_acc_r  <= accepted_r;
      out_term_r <= term_r;
      out_sig_r  <= fatal_sig_r;
      out_pend_r <= pending_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_send_accepted = out_acc_r;
  assign out_terminate     = out_term_r;
  assign out_term_signal   = out_sig_r;
  assign out_pending_after = out_pend_r;

  // The scan index stays within the signals that exist.
  `SPD_ASSERT_SAME(a_scan_idx_range, ctrl.scan,
    (ctrl.idx >= spd_pkg::FIRST_SIG) && (ctrl.idx <= spd_pkg::LAST_SIG))
  // An honoured send leaves its pending bit set.
  `SPD_ASSERT_NEXT(a_send_sets_bit, in_fire && send_ok,
    pending_r[$past(in_signal_number)])
  // Loading the output register always presents a word.
  `SPD_ASSERT_NEXT(a_load_shows_word, ctrl.load_out, out_valid_r)
  // A terminating result always names a real signal.
  `SPD_ASSERT_SAME(a_term_names_signal, out_valid_r && out_term_r,
    out_sig_r != {spd_pkg::SIG_W{1'b0}})

endmodule

`default_nettype wire
